// File: src/flis_pkg.sv
// flis_pkg: shared types, register map and led schedule for the flow lamp sequencer
`timescale 1ns / 1ps

package flis_pkg;

    // input word: one fast tick
    typedef struct packed {
        logic        flow_level;
        logic [15:0] tag_id;
    } flis_tick_t;

    // output word: one result per tick
    typedef struct packed {
        logic       lamp_on;
        logic [2:0] led_color;
        logic       buzzer_on;
        logic       slow_step_done;
    } flis_result_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [7:0]  tick_divide;
        logic [15:0] hold_ticks;
        logic [15:0] slow_ticks_per_second;
        logic [15:0] blink_on_period;
        logic [15:0] blink_off_period;
    } flis_cfg_t;

    // apb register map
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    typedef logic [2:0] flis_reg_idx_t;
    localparam flis_reg_idx_t REG_TICK_DIVIDE  = 3'd0;
    localparam flis_reg_idx_t REG_HOLD_TICKS   = 3'd1;
    localparam flis_reg_idx_t REG_SLOW_PER_SEC = 3'd2;
    localparam flis_reg_idx_t REG_BLINK_ON     = 3'd3;
    localparam flis_reg_idx_t REG_BLINK_OFF    = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_TICK_DIVIDE  = 8'd10;
    localparam logic [15:0] RST_HOLD_TICKS   = 16'd300;
    localparam logic [15:0] RST_SLOW_PER_SEC = 16'd98;
    localparam logic [15:0] RST_BLINK_ON     = 16'd25;
    localparam logic [15:0] RST_BLINK_OFF    = 16'd25;

    // schedule
    localparam logic [6:0] SCHED_LAST  = 7'd119;
    localparam logic [6:0] SCHED_START = 7'd60;
    localparam logic [6:0] SCHED_LEN   = 7'd120;

    // led code fields
    localparam int unsigned LED_BLINK_BIT = 7;

    // schedule lookup: new led code at a position, or the current one kept
    function automatic logic [7:0] flis_sched_code(input logic [6:0] pos,
                                                   input logic [7:0] cur);
        logic [7:0] code;
        code = cur;
        case (pos)
            7'd0:    code = 8'h01;
            7'd15:   code = 8'h82;
            7'd30:   code = 8'h02;
            7'd45:   code = 8'h05;
            7'd60:   code = 8'h84;
            7'd75:   code = 8'h04;
            7'd90:   code = 8'hD4;
            7'd105:  code = 8'h94;
            default: code = cur;
        endcase
        return code;
    endfunction

endpackage

// File: src/flis_cfg_regs.sv
// flis_cfg_regs: apb configuration register file
`timescale 1ns / 1ps

module flis_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [flis_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [flis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [flis_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output flis_pkg::flis_cfg_t             cfg
);

    flis_pkg::flis_cfg_t   cfg_reg;
    flis_pkg::flis_reg_idx_t idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_divide           <= flis_pkg::RST_TICK_DIVIDE;
            cfg_reg.hold_ticks            <= flis_pkg::RST_HOLD_TICKS;
            cfg_reg.slow_ticks_per_second <= flis_pkg::RST_SLOW_PER_SEC;
            cfg_reg.blink_on_period       <= flis_pkg::RST_BLINK_ON;
            cfg_reg.blink_off_period      <= flis_pkg::RST_BLINK_OFF;
        end
        else if (wr_en)
        begin
            unique case (idx)
                flis_pkg::REG_TICK_DIVIDE:  cfg_reg.tick_divide <= pwdata[7:0];
                flis_pkg::REG_HOLD_TICKS:   cfg_reg.hold_ticks <= pwdata[15:0];
                flis_pkg::REG_SLOW_PER_SEC: cfg_reg.slow_ticks_per_second <= pwdata[15:0];
                flis_pkg::REG_BLINK_ON:     cfg_reg.blink_on_period <= pwdata[15:0];
                flis_pkg::REG_BLINK_OFF:    cfg_reg.blink_off_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            flis_pkg::REG_TICK_DIVIDE:  prdata = {24'd0, cfg_reg.tick_divide};
            flis_pkg::REG_HOLD_TICKS:   prdata = {16'd0, cfg_reg.hold_ticks};
            flis_pkg::REG_SLOW_PER_SEC: prdata = {16'd0, cfg_reg.slow_ticks_per_second};
            flis_pkg::REG_BLINK_ON:     prdata = {16'd0, cfg_reg.blink_on_period};
            flis_pkg::REG_BLINK_OFF:    prdata = {16'd0, cfg_reg.blink_off_period};
            default:                    prdata = '0;
        endcase
    end

endmodule

// File: src/flow_lamp_and_indicator_sequencer.sv
// flow_lamp_and_indicator_sequencer: flow pulse lamp hold, led schedule and buzzer per tick
//
//   channel   direction  handshake                  word
//   tick      in         tick_valid / tick_stall    flis_tick_t (flow_level, tag_id)
//   result    out        result_valid / result_stall flis_result_t
//   config    in         apb psel/penable/pwrite    five registers at 4*index
//
// one tick per clock while tick_stall is low; the result word appears in the cycle after the tick is taken
// all state updates in one pass between the tick and the result register
// reset: lamp on, schedule at position 60, led off, config at its defaults
// result_stall holds the result register; tick_stall is raised only while
// a held result is still waiting
`timescale 1ns / 1ps

module flow_lamp_and_indicator_sequencer
#(
    parameter int unsigned PULSE_COUNT_BITS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  flis_pkg::flis_tick_t            tick,
    output logic                            result_valid,
    input  logic                            result_stall,
    output flis_pkg::flis_result_t          result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [flis_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [flis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [flis_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    flis_pkg::flis_cfg_t cfg;

    flis_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state
    logic                        prev_level_reg;
    logic [PULSE_COUNT_BITS-1:0] pulse_count_reg, pulse_count_next;
    logic [PULSE_COUNT_BITS-1:0] count_at_step_reg;
    logic [7:0]                  tick_phase_reg, tick_phase_next;
    logic [15:0]                 hold_reg, hold_next;
    logic [15:0]                 second_phase_reg, second_phase_next;
    logic [6:0]                  sched_pos_reg, sched_pos_next;
    logic [7:0]                  led_code_reg, led_code_next;
    logic                        buzzer_reg, buzzer_next;
    logic [15:0]                 blink_count_reg, blink_count_next;
    logic                        lamp_reg, lamp_next;
    logic [2:0]                  shown_color_reg, shown_color_next;
    logic                        result_valid_reg;
    flis_pkg::flis_result_t      result_reg;

    logic        accept;
    logic        fire;
    logic        advance;
    logic [7:0]  tick_inc;
    logic [15:0] second_inc;
    logic [15:0] blink_inc;
    logic [16:0] blink_limit;
    logic        in_window;

    // handshake: take a tick unless a result is stuck in the output register
    assign tick_stall   = result_valid_reg && result_stall;
    assign accept       = tick_valid && !tick_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // fast tick: pulse count and slow step divider
    assign pulse_count_next = pulse_count_reg
                            + PULSE_COUNT_BITS'(tick.flow_level && !prev_level_reg);
    assign tick_inc         = tick_phase_reg + 8'd1;
    assign fire             = tick_inc >= cfg.tick_divide;
    assign tick_phase_next  = fire ? 8'd0 : tick_inc;

    // schedule advance divider
    assign second_inc        = second_phase_reg + 16'd1;
    assign advance           = second_inc >= cfg.slow_ticks_per_second;
    assign second_phase_next = advance ? 16'd0 : second_inc;

    // slow step datapath
    always_comb
    begin
        // lamp hold
        if (pulse_count_next != count_at_step_reg)
            hold_next = cfg.hold_ticks;
        else if (hold_reg != 16'd0)
            hold_next = hold_reg - 16'd1;
        else
            hold_next = hold_reg;
        lamp_next = hold_next != 16'd0;

        // schedule and buzzer
        if (advance)
        begin
            led_code_next  = flis_pkg::flis_sched_code(sched_pos_reg, led_code_reg);
            sched_pos_next = (sched_pos_reg == flis_pkg::SCHED_LAST) ? 7'd0
                                                                    : sched_pos_reg + 7'd1;
            buzzer_next    = buzzer_reg ^ (tick.tag_id == 16'd0);
        end
        else
        begin
            led_code_next  = led_code_reg;
            sched_pos_next = sched_pos_reg;
            buzzer_next    = buzzer_reg;
        end

        // blink
        blink_inc   = led_code_next[flis_pkg::LED_BLINK_BIT] ? blink_count_reg + 16'd1
                                                             : 16'd0;
        blink_limit = {1'b0, cfg.blink_on_period} + {1'b0, cfg.blink_off_period};
        in_window   = (blink_inc >= cfg.blink_on_period)
                   && ({1'b0, blink_inc} <= blink_limit);
        if (in_window)
        begin
            shown_color_next = led_code_next[6:4];
            blink_count_next = blink_inc;
        end
        else
        begin
            shown_color_next = led_code_next[2:0];
            blink_count_next = ({1'b0, blink_inc} > blink_limit) ? 16'd0 : blink_inc;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg    <= 1'b0;
            pulse_count_reg   <= '0;
            count_at_step_reg <= '0;
            tick_phase_reg    <= 8'd0;
            hold_reg          <= 16'd0;
            second_phase_reg  <= 16'd0;
            sched_pos_reg     <= flis_pkg::SCHED_START;
            led_code_reg      <= 8'd0;
            buzzer_reg        <= 1'b0;
            blink_count_reg   <= 16'd0;
            lamp_reg          <= 1'b1;
            shown_color_reg   <= 3'd0;
        end
        else if (accept)
        begin
            prev_level_reg  <= tick.flow_level;
            pulse_count_reg <= pulse_count_next;
            tick_phase_reg  <= tick_phase_next;
            if (fire)
            begin
                count_at_step_reg <= pulse_count_next;
                hold_reg          <= hold_next;
                lamp_reg          <= lamp_next;
                second_phase_reg  <= second_phase_next;
                sched_pos_reg     <= sched_pos_next;
                led_code_reg      <= led_code_next;
                buzzer_reg        <= buzzer_next;
                blink_count_reg   <= blink_count_next;
                shown_color_reg   <= shown_color_next;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    // result register word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg.lamp_on        <= fire ? lamp_next : lamp_reg;
            result_reg.led_color      <= fire ? shown_color_next : shown_color_reg;
            result_reg.buzzer_on      <= fire ? buzzer_next : buzzer_reg;
            result_reg.slow_step_done <= fire;
        end
    end

    // checks
    a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fire |=> tick_phase_reg == 8'd0)
        else $error("tick phase not cleared after slow step");

    a_sched_range: assert property (@(posedge clk) disable iff (!rst_n)
        sched_pos_reg < flis_pkg::SCHED_LEN)
        else $error("schedule position out of range");

    a_hold_between_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !fire |=> $stable(hold_reg) && $stable(shown_color_reg)
                            && $stable(led_code_reg))
        else $error("slow state changed without a slow step");

    a_blink_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !led_code_reg[flis_pkg::LED_BLINK_BIT] |-> blink_count_reg == 16'd0)
        else $error("blink counter running with blinking off");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg && result_reg.slow_step_done == $past(fire))
        else $error("result word missing after accepted tick");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for the flow lamp and indicator sequencer
`timescale 1ns / 1ps

module tb_top;

    // timing and run sizes
    localparam int QUIET_LIMIT     = 1000;
    localparam int TAIL_CYCLES     = 8;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_TICKS     = 110;
    localparam int WINDOW_TICKS    = 40;
    localparam int MAX_REPORTS     = 50;
    localparam int SCHED_STRIDE    = 15;
    localparam flis_pkg::flis_reg_idx_t REG_SPARE = 3'd5;

    // led codes loaded at schedule positions 0, 15, 30 ... 105
    localparam logic [7:0][7:0] SCHEDULE_CODES = {
        8'h94, 8'hD4, 8'h04, 8'h84, 8'h05, 8'h02, 8'h82, 8'h01
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            tick_valid = 1'b0;
    logic                            tick_stall;
    flis_pkg::flis_tick_t            tick = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    flis_pkg::flis_result_t          result;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [flis_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [flis_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [flis_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // shadow of the sequencer state and its registers
    flis_pkg::flis_cfg_t cfg_shadow;
    logic        last_level;
    logic [7:0]  pulse_count;
    logic [7:0]  count_at_step;
    logic [7:0]  tick_phase;
    logic [15:0] hold_left;
    logic [15:0] second_phase;
    logic [6:0]  sched_pos;
    logic [7:0]  led_code;
    logic        buzzer_level;
    logic [15:0] blink_count;
    logic        lamp_level;
    logic [2:0]  shown_color;

    // output words still to come from the block, oldest first
    flis_pkg::flis_result_t sequencer_outputs [$];

    // stimulus shaping
    bit   idling_enabled = 1'b1;
    int   toggle_pct = 50;
    logic drive_level = 1'b0;
    int   stall_cycles = 0;
    int   quiet_cycles = 0;

    // run statistics
    int n_ticks = 0;
    int n_results = 0;
    int n_slow_steps = 0;
    int n_advances = 0;
    int n_writes = 0;
    int mismatch_count = 0;

    flow_lamp_and_indicator_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic int draw_wait();
        return idling_enabled ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic logic [31:0] reg_mask(input flis_pkg::flis_reg_idx_t idx);
        return (idx == flis_pkg::REG_TICK_DIVIDE) ? 32'h0000_00FF : 32'h0000_FFFF;
    endfunction

    // register value with random junk above its width
    function automatic logic [31:0] with_noise(input flis_pkg::flis_reg_idx_t idx,
                                               input logic [31:0] value);
        return (value & reg_mask(idx)) | ($urandom & ~reg_mask(idx));
    endfunction

    task automatic reset_shadow();
        cfg_shadow.tick_divide           = flis_pkg::RST_TICK_DIVIDE;
        cfg_shadow.hold_ticks            = flis_pkg::RST_HOLD_TICKS;
        cfg_shadow.slow_ticks_per_second = flis_pkg::RST_SLOW_PER_SEC;
        cfg_shadow.blink_on_period       = flis_pkg::RST_BLINK_ON;
        cfg_shadow.blink_off_period      = flis_pkg::RST_BLINK_OFF;
        last_level    = 1'b0;
        pulse_count   = '0;
        count_at_step = '0;
        tick_phase    = '0;
        hold_left     = '0;
        second_phase  = '0;
        sched_pos     = flis_pkg::SCHED_START;
        led_code      = '0;
        buzzer_level  = 1'b0;
        blink_count   = '0;
        lamp_level    = 1'b1;
        shown_color   = '0;
    endtask

    // advance the shadow by one tick and queue the output word it yields
    task automatic step_sequencer(input flis_pkg::flis_tick_t word);
        flis_pkg::flis_result_t out_word;
        logic [16:0]  blink_limit;
        logic [2:0]   color;
        // flow pulse counting on rising edges
        if (word.flow_level && !last_level)
            pulse_count = pulse_count + 8'd1;
        last_level = word.flow_level;
        out_word.slow_step_done = 1'b0;
        tick_phase = tick_phase + 8'd1;
        if (tick_phase >= cfg_shadow.tick_divide)
        begin
            tick_phase = '0;
            out_word.slow_step_done = 1'b1;
            n_slow_steps++;
            // lamp hold
            if (pulse_count != count_at_step)
                hold_left = cfg_shadow.hold_ticks;
            else if (hold_left != 16'd0)
                hold_left = hold_left - 16'd1;
            count_at_step = pulse_count;
            lamp_level = (hold_left != 16'd0);
            // once-per-second schedule and buzzer
            second_phase = second_phase + 16'd1;
            if (second_phase >= cfg_shadow.slow_ticks_per_second)
            begin
                second_phase = '0;
                n_advances++;
                if (sched_pos % SCHED_STRIDE == 0)
                    led_code = SCHEDULE_CODES[sched_pos / SCHED_STRIDE];
                sched_pos = (sched_pos == flis_pkg::SCHED_LAST) ? 7'd0 : sched_pos + 7'd1;
                if (word.tag_id == 16'd0)
                    buzzer_level = ~buzzer_level;
            end
            // blink window, sum kept at 17 bits
            blink_limit = {1'b0, cfg_shadow.blink_on_period}
                        + {1'b0, cfg_shadow.blink_off_period};
            color = led_code[2:0];
            if (!led_code[flis_pkg::LED_BLINK_BIT])
                blink_count = '0;
            else
                blink_count = blink_count + 16'd1;
            if (blink_count >= cfg_shadow.blink_on_period
                && {1'b0, blink_count} <= blink_limit)
                color = led_code[6:4];
            else if ({1'b0, blink_count} > blink_limit)
                blink_count = '0;
            shown_color = color;
        end
        out_word.lamp_on   = lamp_level;
        out_word.led_color = shown_color;
        out_word.buzzer_on = buzzer_level;
        sequencer_outputs.push_back(out_word);
    endtask

    // send one tick word and wait until the block takes it
    task automatic send_tick(input flis_pkg::flis_tick_t word);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick       <= word;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        n_ticks++;
        step_sequencer(word);
    endtask

    task automatic send_random_tick();
        flis_pkg::flis_tick_t word;
        int         pick;
        if ($urandom_range(0, 99) < toggle_pct)
            drive_level = ~drive_level;
        pick = $urandom_range(0, 99);
        word.flow_level = drive_level;
        if (pick < 35)
            word.tag_id = '0;
        else if (pick < 45)
            word.tag_id = '1;
        else
            word.tag_id = 16'($urandom);
        send_tick(word);
    endtask

    // stop sending and wait for every outstanding output word
    task automatic wait_outputs_drained();
        tick_valid <= 1'b0;
        while (sequencer_outputs.size() != 0)
            @(posedge clk);
    endtask

    // apb write, psel left high for back-to-back transfers
    task automatic write_register(input flis_pkg::flis_reg_idx_t idx,
                                  input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= flis_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        n_writes++;
        case (idx)
            flis_pkg::REG_TICK_DIVIDE:  cfg_shadow.tick_divide           = data[7:0];
            flis_pkg::REG_HOLD_TICKS:   cfg_shadow.hold_ticks            = data[15:0];
            flis_pkg::REG_SLOW_PER_SEC: cfg_shadow.slow_ticks_per_second = data[15:0];
            flis_pkg::REG_BLINK_ON:     cfg_shadow.blink_on_period       = data[15:0];
            flis_pkg::REG_BLINK_OFF:    cfg_shadow.blink_off_period      = data[15:0];
            default:          ;
        endcase
    endtask

    // read back every register and compare with the shadow
    task automatic check_registers();
        int            idx;
        logic [31:0]   want;
        for (idx = flis_pkg::REG_TICK_DIVIDE; idx <= flis_pkg::REG_BLINK_OFF; idx++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= flis_pkg::APB_ADDR_W'({flis_pkg::flis_reg_idx_t'(idx), 2'b00});
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            case (flis_pkg::flis_reg_idx_t'(idx))
                flis_pkg::REG_TICK_DIVIDE:  want = 32'(cfg_shadow.tick_divide);
                flis_pkg::REG_HOLD_TICKS:   want = 32'(cfg_shadow.hold_ticks);
                flis_pkg::REG_SLOW_PER_SEC: want = 32'(cfg_shadow.slow_ticks_per_second);
                flis_pkg::REG_BLINK_ON:     want = 32'(cfg_shadow.blink_on_period);
                default:                    want = 32'(cfg_shadow.blink_off_period);
            endcase
            if (prdata !== want)
                report_mismatch($sformatf("register %0d reads %h, want %h",
                                          idx, prdata, want));
        end
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // output word check and random result stall
    always @(posedge clk)
    begin
        flis_pkg::flis_result_t want;
        logic         next_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (sequencer_outputs.size() == 0)
                report_mismatch($sformatf("unexpected output word %h", result));
            else
            begin
                want = sequencer_outputs.pop_front();
                if (result.lamp_on !== want.lamp_on)
                    report_mismatch($sformatf("lamp_on %b, want %b",
                                              result.lamp_on, want.lamp_on));
                if (result.led_color !== want.led_color)
                    report_mismatch($sformatf("led_color %0d, want %0d",
                                              result.led_color, want.led_color));
                if (result.buzzer_on !== want.buzzer_on)
                    report_mismatch($sformatf("buzzer_on %b, want %b",
                                              result.buzzer_on, want.buzzer_on));
                if (result.slow_step_done !== want.slow_step_done)
                    report_mismatch($sformatf("slow_step_done %b, want %b",
                                              result.slow_step_done,
                                              want.slow_step_done));
            end
            stall_cycles = draw_wait();
        end
        next_stall = 1'b0;
        if (stall_cycles > 0)
        begin
            next_stall = 1'b1;
            stall_cycles--;
        end
        result_stall <= next_stall;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((tick_valid && !tick_stall) || (result_valid && !result_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // reset values, a first slow step at the default divider
    task automatic test_reset_defaults();
        flis_pkg::flis_tick_t word;
        int         i;
        check_registers();
        bus_release();
        for (i = 0; i < 10; i++)
        begin
            word.flow_level = i[0];
            word.tag_id = (i % 3 == 0) ? 16'h0000 : (i % 3 == 1) ? 16'hFFFF : 16'($urandom);
            send_tick(word);
        end
    endtask

    // all registers at zero: every tick is a slow step and a schedule advance
    task automatic test_zero_dividers();
        flis_pkg::flis_tick_t word;
        int         i;
        wait_outputs_drained();
        write_register(flis_pkg::REG_TICK_DIVIDE, with_noise(flis_pkg::REG_TICK_DIVIDE, 0));
        write_register(flis_pkg::REG_HOLD_TICKS, with_noise(flis_pkg::REG_HOLD_TICKS, 0));
        write_register(flis_pkg::REG_SLOW_PER_SEC,
                       with_noise(flis_pkg::REG_SLOW_PER_SEC, 0));
        write_register(flis_pkg::REG_BLINK_ON, with_noise(flis_pkg::REG_BLINK_ON, 0));
        write_register(flis_pkg::REG_BLINK_OFF, with_noise(flis_pkg::REG_BLINK_OFF, 0));
        check_registers();
        bus_release();
        for (i = 0; i < 8; i++)
        begin
            word.flow_level = ~i[0];
            word.tag_id = i[0] ? 16'hFFFF : 16'h0000;
            send_tick(word);
        end
    endtask

    // all registers at maximum, spare addresses, then a divider lowered below its phase
    task automatic test_upper_limits();
        flis_pkg::flis_tick_t word;
        int         i;
        wait_outputs_drained();
        write_register(flis_pkg::REG_TICK_DIVIDE, 32'hFFFF_FFFF);
        write_register(flis_pkg::REG_HOLD_TICKS, 32'hFFFF_FFFF);
        write_register(flis_pkg::REG_SLOW_PER_SEC, 32'hFFFF_FFFF);
        write_register(flis_pkg::REG_BLINK_ON, 32'hFFFF_FFFF);
        write_register(flis_pkg::REG_BLINK_OFF, 32'hFFFF_FFFF);
        for (i = REG_SPARE; i < (1 << $bits(flis_pkg::flis_reg_idx_t)); i++)
            write_register(flis_pkg::flis_reg_idx_t'(i), $urandom);
        check_registers();
        bus_release();
        for (i = 0; i < 5; i++)
        begin
            word.flow_level = (i == 0 || i == 1 || i == 4);
            word.tag_id = 16'($urandom);
            send_tick(word);
        end
        wait_outputs_drained();
        write_register(flis_pkg::REG_TICK_DIVIDE, with_noise(flis_pkg::REG_TICK_DIVIDE, 2));
        check_registers();
        bus_release();
        for (i = 0; i < 2; i++)
        begin
            word.flow_level = i[0];
            word.tag_id = 16'h0000;
            send_tick(word);
        end
    endtask

    // narrow blink window watched over several main and alternate color spans
    task automatic test_blink_window();
        int i;
        wait_outputs_drained();
        write_register(flis_pkg::REG_TICK_DIVIDE, with_noise(flis_pkg::REG_TICK_DIVIDE, 0));
        write_register(flis_pkg::REG_SLOW_PER_SEC,
                       with_noise(flis_pkg::REG_SLOW_PER_SEC, 0));
        bus_release();
        idling_enabled = 1'b1;
        toggle_pct = 30;
        // step the schedule until a blinking code is loaded
        while (!led_code[flis_pkg::LED_BLINK_BIT] || sched_pos % SCHED_STRIDE == 0)
            send_random_tick();
        wait_outputs_drained();
        write_register(flis_pkg::REG_TICK_DIVIDE, with_noise(flis_pkg::REG_TICK_DIVIDE, 1));
        write_register(flis_pkg::REG_HOLD_TICKS, with_noise(flis_pkg::REG_HOLD_TICKS, 3));
        write_register(flis_pkg::REG_SLOW_PER_SEC,
                       with_noise(flis_pkg::REG_SLOW_PER_SEC, 65535));
        write_register(flis_pkg::REG_BLINK_ON, with_noise(flis_pkg::REG_BLINK_ON, 5));
        write_register(flis_pkg::REG_BLINK_OFF, with_noise(flis_pkg::REG_BLINK_OFF, 3));
        check_registers();
        bus_release();
        idling_enabled = 1'b0;
        toggle_pct = 2;
        for (i = 0; i < WINDOW_TICKS; i++)
            send_random_tick();
    endtask

    function automatic logic [31:0] draw_register_value(input flis_pkg::flis_reg_idx_t idx);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return with_noise(idx, $urandom_range(0, 4));
        else if (pick < 85)
            return with_noise(idx, $urandom_range(5, 40));
        else if (pick < 93)
            return $urandom;
        else if (pick < 96)
            return with_noise(idx, 0);
        return 32'hFFFF_FFFF;
    endfunction

    // phases of random ticks, each under fresh register settings
    task automatic test_random_phases();
        int phase;
        int idx;
        int pick;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_outputs_drained();
            for (idx = flis_pkg::REG_TICK_DIVIDE; idx <= flis_pkg::REG_BLINK_OFF; idx++)
                if (phase == 0 || $urandom_range(0, 3) != 0)
                    write_register(flis_pkg::flis_reg_idx_t'(idx),
                                   draw_register_value(flis_pkg::flis_reg_idx_t'(idx)));
            check_registers();
            bus_release();
            idling_enabled = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 3);
            toggle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 50 : 100;
            repeat (PHASE_TICKS)
                send_random_tick();
        end
    endtask

    initial
    begin
        reset_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_dividers();
        test_upper_limits();
        test_blink_window();
        test_random_phases();
        // drain and give stray words time to show up
        wait_outputs_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sequencer_outputs.size() != 0)
            report_mismatch($sformatf("%0d output words never arrived",
                                      sequencer_outputs.size()));
        $display("run covered %0d ticks and %0d output words,", n_ticks, n_results);
        $display("%0d slow steps, %0d schedule advances, %0d register writes, %0d mismatches",
                 n_slow_steps, n_advances, n_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/flis_pkg.sv
src/flis_cfg_regs.sv
src/flow_lamp_and_indicator_sequencer.sv
tb/sv/tb_top.sv
